// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Constants, types and codes shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PAYLOAD_BYTES = 18;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 2);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int BYTE_INDEX_W  = 5;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] END_BYTE   = 8'hFE;
    localparam logic [7:0] ERROR_MARK = 8'h40;

    localparam logic [7:0] TYPE_FIRST_RST  = 8'h0B;
    localparam logic [7:0] TYPE_SECOND_RST = 8'h01;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_SECOND = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic             step;   // process the byte on the input channel
        logic             load;   // load the output register from the store
        logic [IDX_W-1:0] idx;    // store entry to load
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic deliver;            // input byte closes a frame
    } t_status;

endpackage

// ===== sv/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the serial frame receiver: input, output, config.
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       parity_error;

    modport source (output valid, output rx_byte, output parity_error, input ready);
    modport sink   (input valid, input rx_byte, input parity_error, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last_byte;
    logic       frame_error;

    modport source (output valid, output data_byte, output byte_index,
                    output last_byte, output frame_error, input ready);
    modport sink   (input valid, input data_byte, input byte_index,
                    input last_byte, input frame_error, output ready);
endinterface

interface sfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sfr_datapath.sv =====
// ----------------------------------------------------------------------------
// sfr_datapath
// Frame state (position, sum, error, previous byte), payload store,
// type code registers and the output register.
// ----------------------------------------------------------------------------
module sfr_datapath
    import sfr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_parity_error,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    output logic [7:0]              o_data_byte,
    output logic [BYTE_INDEX_W-1:0] o_byte_index,
    output logic                    o_last_byte,
    output logic                    o_frame_error
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_err, n_err;
    logic [7:0]       r_prev;
    logic [7:0]       r_type_first, r_type_second;
    logic [7:0]       r_store [PAYLOAD_BYTES];
    logic             store_we;

    logic [7:0]              r_data;
    logic [BYTE_INDEX_W-1:0] r_index;
    logic                    r_last;

    logic at_sum_slot, at_end_slot, start_pair, type_bad;

    assign at_sum_slot = (r_pos == POS_W'(PAYLOAD_BYTES));
    assign at_end_slot = (r_pos == POS_W'(PAYLOAD_BYTES + 1));
    assign start_pair  = (r_prev == START_BYTE) && (i_rx_byte == START_BYTE);
    // entry 1 holds the type byte
    assign type_bad    = (r_store[1] != r_type_first) && (r_store[1] != r_type_second);

    assign o_status.deliver = at_end_slot && (i_rx_byte == END_BYTE);

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_err    = r_err | i_parity_error;
        store_we = 1'b0;
        if (at_sum_slot) begin
            if (i_rx_byte != r_sum) begin
                n_err = 1'b1;
            end
            n_pos = r_pos + POS_W'(1);
        end else if (start_pair) begin
            n_pos = '0;
            n_sum = '0;
            n_err = 1'b0;
        end else if (at_end_slot) begin
            if (type_bad) begin
                n_err = 1'b1;
            end
            if (i_rx_byte == END_BYTE) begin
                n_pos = '0;
            end
        end else if (r_pos < POS_W'(PAYLOAD_BYTES)) begin
            store_we = 1'b1;
            n_sum    = r_sum + i_rx_byte;
            n_pos    = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_err  <= 1'b0;
            r_prev <= '0;
        end else if (i_cmd.step) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_err  <= n_err;
            r_prev <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_first  <= TYPE_FIRST_RST;
            r_type_second <= TYPE_SECOND_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_TYPE_FIRST) begin
                r_type_first <= i_cfg_data;
            end
            if (i_cfg_index == REG_TYPE_SECOND) begin
                r_type_second <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && store_we) begin
            r_store[r_pos[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // output register; the error mark goes on the type byte only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data  <= r_store[i_cmd.idx] |
                       (((i_cmd.idx == IDX_W'(1)) && r_err) ? ERROR_MARK : 8'h00);
            r_index <= BYTE_INDEX_W'(i_cmd.idx);
            r_last  <= (i_cmd.idx == IDX_W'(PAYLOAD_BYTES - 1));
        end
    end

    assign o_data_byte   = r_data;
    assign o_byte_index  = r_index;
    assign o_last_byte   = r_last;
    assign o_frame_error = r_err;

endmodule

// ===== sv/sfr_controller.sv =====
// ----------------------------------------------------------------------------
// sfr_controller
// Accepts bytes while idle and drains the payload one item per handshake
// after a frame closes.
// ----------------------------------------------------------------------------
module sfr_controller
    import sfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             step, load, idx_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SHOW);
    assign step        = i_in_valid && (r_state == S_IDLE);
    assign idx_last    = (r_idx == IDX_W'(PAYLOAD_BYTES - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (step && i_status.deliver) begin
                    n_state = S_LOAD;
                    n_idx   = '0;
                end
            end
            S_LOAD: begin
                load    = 1'b1;
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (i_out_ready) begin
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                        load  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.step = step;
    assign o_cmd.load = load;
    assign o_cmd.idx  = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while draining");

    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_status.deliver) |=> (r_state == S_LOAD) && (r_idx == '0))
        else $error("drain did not start at entry zero");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && idx_last) |=> o_in_ready)
        else $error("not idle after last item");

    a_hold_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(r_idx))
        else $error("drain index moved while stalled");

endmodule

// ===== sv/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Framed serial byte receiver with checksum, type and parity checking.
//
// i_in takes one received byte with its parity error flag per item. A frame
// is a 0xFF 0xFF start pair, 18 payload bytes, a checksum byte (8-bit sum of
// the payload) and a 0xFE end byte. On the end byte, o_out delivers the 18
// payload bytes as items with byte_index 0..17, last_byte on the final one;
// frame_error and bit 6 of byte 1 flag a parity, checksum or type fault.
// i_cfg writes the two accepted type codes (index 0 and 1); it is always
// ready and is meant to be written while the block is idle.
// Input bytes are accepted back to back while idle. After the end byte the
// controller passes through S_LOAD to load the output register, then shows
// one item per cycle while o_out is ready; i_in is held not ready during
// the drain. A stall on o_out holds the current item and the drain index.
// Synchronous reset clears position, sum, error and previous byte, and sets
// the type codes to 0x0B and 0x01.
// ----------------------------------------------------------------------------
module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sfr_in_if.sink    i_in,
    sfr_out_if.source o_out,
    sfr_cfg_if.sink   i_cfg
);

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    sfr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sfr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_rx_byte      (i_in.rx_byte),
        .i_parity_error (i_in.parity_error),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_data_byte    (o_out.data_byte),
        .o_byte_index   (o_out.byte_index),
        .o_last_byte    (o_out.last_byte),
        .o_frame_error  (o_out.frame_error)
    );

endmodule
